### design/pezv_pkg.sv
// pezv_pkg: shared constants, types and the arctangent table for the phase error block
// no dependencies
package pezv_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int ANGLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int BAND_W     = 15;
	localparam int NORM_W     = 24;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int ZACC_W     = 32;
	localparam int ATAN_LEN   = 24;

	localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(1024);
	localparam logic [NORM_W-1:0] NORM_RESET = NORM_W'(1);

	// register select, taken from paddr[2]
	localparam logic REG_PHASE_BAND = 1'b0;
	localparam logic REG_NORM_THR   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_A,
		ST_SQ_B,
		ST_ADD,
		ST_RUN,
		ST_FIN,
		ST_THR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic init;
		logic step;
	} polar_ctl_t;

	// atan(2^-i), 2^31 equals pi
	function automatic logic [ZACC_W-1:0] atan_step(input logic [4:0] idx);
		logic [ZACC_W-1:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### design/pezv_item_if.sv
// pezv_item_if: input channel, one beat carries a measured and a reference vector
// depends on pezv_pkg
interface pezv_item_if
	import pezv_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] meas_a;
	logic signed [SAMPLE_WIDTH-1:0] meas_b;
	logic signed [SAMPLE_WIDTH-1:0] target_a;
	logic signed [SAMPLE_WIDTH-1:0] target_b;

	modport source (output valid, meas_a, meas_b, target_a, target_b, input ready);
	modport sink (input valid, meas_a, meas_b, target_a, target_b, output ready);
endinterface

### design/pezv_result_if.sv
// pezv_result_if: output channel, one beat carries magnitudes, phases, error and flags
// depends on pezv_pkg
interface pezv_result_if
	import pezv_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [SAMPLE_WIDTH-1:0]       meas_magnitude;
	logic [SAMPLE_WIDTH-1:0]       target_magnitude;
	logic signed [ANGLE_WIDTH-1:0] meas_phase;
	logic signed [ANGLE_WIDTH-1:0] target_phase;
	logic signed [ANGLE_WIDTH-1:0] phase_error;
	logic                          zero_vector_flag;
	logic                          integrate_enable;

	modport source (output valid, meas_magnitude, target_magnitude, meas_phase,
		target_phase, phase_error, zero_vector_flag, integrate_enable, input ready);
	modport sink (input valid, meas_magnitude, target_magnitude, meas_phase,
		target_phase, phase_error, zero_vector_flag, integrate_enable, output ready);
endinterface

### design/phase_error_zero_vector_hysteresis.sv
// phase_error_zero_vector_hysteresis: top level, sequencer, shared multiplier, APB registers
// depends on pezv_pkg, pezv_item_if, pezv_result_if, pezv_polar
//
// Takes a measured and a reference (alpha, beta) vector per input beat and returns one result
// beat: both magnitudes (rounded, saturating), both phases (2^(ANGLE_WIDTH-1) is pi), the
// wrapped phase error, the zero-vector hysteresis flag and the integrate enable. Each item
// runs the shared multiplier passes for the squares, then the square-root recurrence, which
// yields one result bit per cycle and runs alongside the CORDIC iterations, once per vector,
// and a last multiplier pass for the threshold. The input is not ready while an item is at
// work; a finished result sits in an output register, so the next item may be taken while it
// waits. Registers: phase_band at 0x0, norm_threshold at 0x4.
module phase_error_zero_vector_hysteresis
	import pezv_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pezv_item_if.sink              item,
	pezv_result_if.source          result,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);
	localparam int SW      = SAMPLE_WIDTH;
	localparam int AW      = ANGLE_WIDTH;
	localparam int RUN_LEN = (SW > CORDIC_STEPS) ? SW : CORDIC_STEPS;
	localparam int IW      = $clog2(RUN_LEN);
	localparam int MW      = ((SW > NORM_W) ? SW : NORM_W) + 1;
	localparam int PW      = 2 * (MW - 1);
	localparam int CW      = ((AW + 2) > (BAND_W + 2)) ? (AW + 2) : (BAND_W + 2);

	state_t state_q, state_nxt;

	logic [BAND_W-1:0]     band_q;
	logic [NORM_W-1:0]     thr_q;
	logic                  flag_q;
	logic                  sel_q;
	logic [IW-1:0]         cnt_q;
	logic                  out_valid_q;

	logic signed [SW-1:0]  ma_q, mb_q, ta_q, tb_q;
	logic [PW-1:0]         prod_q, sum_q;
	logic [SW-1:0]         mmag_q, tmag_q;
	logic [AW-1:0]         mph_q, tph_q;

	logic [SW-1:0]         res_mmag_q, res_tmag_q;
	logic [AW-1:0]         res_mph_q, res_tph_q, res_err_q;
	logic                  res_int_q;

	logic signed [MW-1:0]  mul_op;
	logic signed [2*MW-1:0] mul_full;
	logic [PW-1:0]         sum_nxt;
	logic signed [SW-1:0]  comp_a, comp_b;
	logic [SW-1:0]         magnitude;
	logic [AW-1:0]         phase;
	logic [AW-1:0]         err;
	logic signed [CW-1:0]  twice, band_s;
	logic                  flag_nxt;
	logic                  run_last, out_free, cfg_wr;
	polar_ctl_t            ctl;

	// apb registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= BAND_RESET;
			thr_q  <= NORM_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PHASE_BAND: band_q <= pwdata[BAND_W-1:0];
				REG_NORM_THR:   thr_q  <= pwdata[NORM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PHASE_BAND: prdata = APB_DATA_W'(band_q);
			REG_NORM_THR:   prdata = APB_DATA_W'(thr_q);
			default:        prdata = '0;
		endcase
	end

	// next state
	assign run_last = cnt_q == IW'(RUN_LEN - 1);
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (item.valid) state_nxt = ST_SQ_A;
			ST_SQ_A: state_nxt = ST_SQ_B;
			ST_SQ_B: state_nxt = ST_ADD;
			ST_ADD:  state_nxt = ST_RUN;
			ST_RUN:  if (run_last) state_nxt = ST_FIN;
			ST_FIN:  state_nxt = sel_q ? ST_THR : ST_SQ_A;
			ST_THR:  state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item.ready = 1'b0;
		ctl        = '0;
		case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_ADD:  ctl.init   = 1'b1;
			ST_RUN:  ctl.step   = 1'b1;
			default: ;
		endcase
	end

	// shared multiplier
	assign comp_a = sel_q ? ta_q : ma_q;
	assign comp_b = sel_q ? tb_q : mb_q;

	always_comb begin
		case (state_q)
			ST_SQ_A: mul_op = MW'(comp_a);
			ST_SQ_B: mul_op = MW'(comp_b);
			ST_THR:  mul_op = $signed(MW'(thr_q));
			default: mul_op = '0;
		endcase
		mul_full = mul_op * mul_op;
		sum_nxt  = sum_q + prod_q;
	end

	pezv_polar #(
		.SAMPLE_WIDTH (SW),
		.ANGLE_WIDTH  (AW),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_polar (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.idx       (cnt_q),
		.comp_a    (comp_a),
		.comp_b    (comp_b),
		.sum_sq    (sum_nxt[2*SW-1:0]),
		.magnitude (magnitude),
		.phase     (phase)
	);

	// error and hysteresis
	always_comb begin
		err      = mph_q - tph_q;
		twice    = CW'($signed(err)) <<< 1;
		band_s   = $signed(CW'(band_q));
		flag_nxt = flag_q;
		if (twice > band_s)
			flag_nxt = 1'b1;
		else if (flag_q && (twice < -band_s))
			flag_nxt = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flag_q      <= 1'b0;
			sel_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE)
				sel_q <= 1'b0;
			else if (state_q == ST_FIN)
				sel_q <= 1'b1;
			if (state_q == ST_RUN)
				cnt_q <= cnt_q + IW'(1);
			else
				cnt_q <= '0;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				flag_q      <= flag_nxt;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			ma_q <= item.meas_a;
			mb_q <= item.meas_b;
			ta_q <= item.target_a;
			tb_q <= item.target_b;
		end
		if (state_q inside {ST_SQ_A, ST_SQ_B, ST_THR})
			prod_q <= mul_full[PW-1:0];
		if (state_q == ST_SQ_B)
			sum_q <= prod_q;
		else if (state_q == ST_ADD)
			sum_q <= sum_nxt;
		if (state_q == ST_FIN) begin
			if (sel_q) begin
				tmag_q <= magnitude;
				tph_q  <= phase;
			end else begin
				mmag_q <= magnitude;
				mph_q  <= phase;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			res_mmag_q <= mmag_q;
			res_tmag_q <= tmag_q;
			res_mph_q  <= mph_q;
			res_tph_q  <= tph_q;
			res_err_q  <= err;
			res_int_q  <= sum_q > prod_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.meas_magnitude   = res_mmag_q;
	assign result.target_magnitude = res_tmag_q;
	assign result.meas_phase       = res_mph_q;
	assign result.target_phase     = res_tph_q;
	assign result.phase_error      = res_err_q;
	assign result.zero_vector_flag = flag_q;
	assign result.integrate_enable = res_int_q;
endmodule

### design/pezv_polar.sv
// pezv_polar: iterative square root and CORDIC vectoring unit, one step per cycle while ctl.step is high
// depends on pezv_pkg
module pezv_polar
	import pezv_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	localparam int RUN_LEN     = (SAMPLE_WIDTH > CORDIC_STEPS) ? SAMPLE_WIDTH : CORDIC_STEPS,
	localparam int IW          = $clog2(RUN_LEN)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  polar_ctl_t                     ctl,
	input  logic [IW-1:0]                  idx,
	input  logic signed [SAMPLE_WIDTH-1:0] comp_a,
	input  logic signed [SAMPLE_WIDTH-1:0] comp_b,
	input  logic [2*SAMPLE_WIDTH-1:0]      sum_sq,
	output logic [SAMPLE_WIDTH-1:0]        magnitude,
	output logic [ANGLE_WIDTH-1:0]         phase
);
	localparam int SW    = SAMPLE_WIDTH;
	localparam int GUARD = 40 - SW;
	localparam int XW    = 43;
	localparam int RW    = SW + 3;

	logic signed [XW-1:0]    x_q, y_q;
	logic [ZACC_W-1:0]       z_q;
	logic                    zero_q;
	logic [2*SW-1:0]         rad_q;
	logic [RW-1:0]           rem_q;
	logic [SW-1:0]           root_q;

	logic signed [XW-1:0]    ax, bx, dx, dy;
	logic [ZACC_W-1:0]       atan_v, z_rnd;
	logic [RW-1:0]           rem_sh;
	logic [RW:0]             trial;
	logic [SW:0]             mag_rnd;
	logic                    cordic_on, sqrt_on;

	always_comb begin
		ax        = XW'(comp_a) <<< GUARD;
		bx        = XW'(comp_b) <<< GUARD;
		dx        = y_q >>> idx;
		dy        = x_q >>> idx;
		atan_v    = atan_step(5'(idx));
		cordic_on = 32'(idx) < CORDIC_STEPS;
		sqrt_on   = 32'(idx) < SW;
		rem_sh    = {rem_q[RW-3:0], rad_q[2*SW-1 -: 2]};
		trial     = {1'b0, rem_sh} - {1'b0, RW'({root_q, 2'b01})};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
		end else if (ctl.init) begin
			zero_q <= (comp_a == '0) && (comp_b == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			if (ax < 0) begin
				x_q <= -ax;
				y_q <= -bx;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= ax;
				y_q <= bx;
				z_q <= '0;
			end
			rad_q  <= sum_sq;
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctl.step) begin
			if (cordic_on) begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_v;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_v;
				end
			end
			if (sqrt_on) begin
				rad_q <= rad_q << 2;
				if (!trial[RW]) begin
					rem_q  <= trial[RW-1:0];
					root_q <= {root_q[SW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[SW-2:0], 1'b0};
				end
			end
		end
	end

	// round to nearest, saturate
	always_comb begin
		mag_rnd   = {1'b0, root_q} + ((rem_q > RW'(root_q)) ? (SW+1)'(1) : '0);
		magnitude = mag_rnd[SW] ? '1 : mag_rnd[SW-1:0];
		z_rnd     = z_q + (ZACC_W'(1) << (31 - ANGLE_WIDTH));
		phase     = zero_q ? '0 : z_rnd[ZACC_W-1 -: ANGLE_WIDTH];
	end
endmodule

### bench/tb.sv
// tb: self-checking bench for phase_error_zero_vector_hysteresis, polar conversion of two vectors
// depends on pezv_pkg, pezv_item_if, pezv_result_if and the block itself
// a directed table and random vector pairs are checked per beat against typed rows or a bit-true predictor
module tb
	import pezv_pkg::*;
();

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int AW = ANGLE_WIDTH_DEF;
	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam int GUARD = 40 - SW;
	localparam int TAIL_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint unsigned MAG_MAX = (64'd1 << SW) - 64'd1;

	localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] S_MIN = 24'sh800000;
	localparam logic signed [SW-1:0] S_ONE = 24'sd1;
	localparam logic signed [SW-1:0] S_NEG1 = -24'sd1;
	localparam logic signed [SW-1:0] S_ZERO = 24'sd0;

	localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic signed [SW-1:0] meas_a;
		logic signed [SW-1:0] meas_b;
		logic signed [SW-1:0] target_a;
		logic signed [SW-1:0] target_b;
	} vec_pair_t;

	typedef struct packed {
		logic [SW-1:0]        meas_magnitude;
		logic [SW-1:0]        target_magnitude;
		logic signed [AW-1:0] meas_phase;
		logic signed [AW-1:0] target_phase;
		logic signed [AW-1:0] phase_error;
		logic                 zero_vector_flag;
		logic                 integrate_enable;
	} polar_result_t;

	typedef struct packed {
		vec_pair_t     v;
		logic          typed;
		polar_result_t want;
	} stim_row_t;

	localparam polar_result_t NO_WANT = '0;

	// after reset: band 1024, threshold 1, flag clear
	localparam stim_row_t DIRECTED [19] = '{
		'{'{S_ZERO, S_ZERO, S_ZERO, S_ZERO}, 1'b1,
			'{24'd0, 24'd0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0}},
		'{'{S_MIN, S_ZERO, S_ZERO, S_ZERO}, 1'b1,
			'{24'd8388608, 24'd0, 16'sh8000, 16'sh0000, 16'sh8000, 1'b0, 1'b0}},
		'{'{S_ZERO, S_ZERO, S_MIN, S_ZERO}, 1'b1,
			'{24'd0, 24'd8388608, 16'sh0000, 16'sh8000, 16'sh8000, 1'b0, 1'b1}},
		'{'{S_MAX, S_ZERO, S_ZERO, S_ZERO}, 1'b0, NO_WANT},
		'{'{S_ZERO, S_MAX, S_ZERO, S_ZERO}, 1'b0, NO_WANT},
		'{'{S_MAX, S_MAX, S_MAX, S_MAX}, 1'b0, NO_WANT},
		'{'{S_ZERO, S_MIN, S_ZERO, S_ZERO}, 1'b0, NO_WANT},
		'{'{S_MIN, S_MIN, S_MAX, S_MAX}, 1'b0, NO_WANT},
		'{'{S_MAX, S_MIN, S_MIN, S_MAX}, 1'b0, NO_WANT},
		'{'{S_MIN, S_MAX, S_MAX, S_MIN}, 1'b0, NO_WANT},
		'{'{S_ONE, S_ZERO, S_ONE, S_ZERO}, 1'b0, NO_WANT},
		'{'{S_ONE, S_ONE, S_ONE, S_ONE}, 1'b0, NO_WANT},
		'{'{S_NEG1, S_NEG1, S_ONE, S_ZERO}, 1'b0, NO_WANT},
		'{'{S_NEG1, S_ZERO, S_ZERO, S_NEG1}, 1'b0, NO_WANT},
		'{'{S_ZERO, S_ONE, S_NEG1, S_ZERO}, 1'b0, NO_WANT},
		'{'{S_MIN, S_NEG1, S_MIN, S_ONE}, 1'b0, NO_WANT},
		'{'{S_MIN, S_ONE, S_MIN, S_NEG1}, 1'b0, NO_WANT},
		'{'{S_MAX, S_ONE, S_MAX, S_ZERO}, 1'b0, NO_WANT},
		'{'{S_ZERO, S_ZERO, S_ZERO, S_MAX}, 1'b0, NO_WANT}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pezv_item_if   item_ch ();
	pezv_result_if result_ch ();

	phase_error_zero_vector_hysteresis dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [BAND_W-1:0] band_setting = BAND_RESET;
	logic [NORM_W-1:0] thr_setting = NORM_RESET;
	logic              zv_state = 1'b0;
	polar_result_t     awaited_results [$];
	int                mismatches = 0;
	int                cycles = 0;
	bit                quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic longint unsigned root_rounded(input longint unsigned s);
		longint unsigned r, probe, rest;
		r = 0;
		probe = 64'd1 << 62;
		rest = s;
		while (probe > s)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= r + probe) begin
				rest = rest - (r + probe);
				r = (r >> 1) + probe;
			end else begin
				r = r >> 1;
			end
			probe = probe >> 2;
		end
		if (s - r * r > r)
			r = r + 1;
		return r;
	endfunction

	function automatic void polar_of(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b,
		output logic [SW-1:0] mag, output logic signed [AW-1:0] ph);
		longint x, y, dx, dy;
		longint unsigned root;
		logic [31:0] z;
		root = root_rounded(longint'(a) * longint'(a) + longint'(b) * longint'(b));
		mag = (root > MAG_MAX) ? SW'(MAG_MAX) : root[SW-1:0];
		ph = '0;
		if (a == 0 && b == 0)
			return;
		x = longint'(a) <<< GUARD;
		y = longint'(b) <<< GUARD;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TABLE[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TABLE[i];
			end
		end
		z = z + (32'd1 << (31 - AW));
		ph = z[31 -: AW];
	endfunction

	// advances the kept flag, so call once per accepted beat
	function automatic polar_result_t predict_polar(input vec_pair_t v);
		polar_result_t res;
		logic [AW-1:0] diff;
		int twice;
		longint unsigned tsq, thr_sq;
		polar_of(v.meas_a, v.meas_b, res.meas_magnitude, res.meas_phase);
		polar_of(v.target_a, v.target_b, res.target_magnitude, res.target_phase);
		diff = res.meas_phase - res.target_phase;
		res.phase_error = diff;
		twice = 2 * int'($signed(diff));
		if (twice > int'(band_setting))
			zv_state = 1'b1;
		else if (zv_state && twice < -int'(band_setting))
			zv_state = 1'b0;
		res.zero_vector_flag = zv_state;
		tsq = longint'(v.target_a) * longint'(v.target_a)
			+ longint'(v.target_b) * longint'(v.target_b);
		thr_sq = longint'(thr_setting) * longint'(thr_setting);
		res.integrate_enable = tsq > thr_sq;
		return res;
	endfunction

	function automatic logic signed [SW-1:0] random_component();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return SW'($urandom());
			5: return SW'(int'($urandom_range(32)) - 16);
			6: begin
				case ($urandom_range(4))
					0: return S_MIN;
					1: return S_MAX;
					2: return S_ZERO;
					3: return S_ONE;
					default: return S_NEG1;
				endcase
			end
			default: return SW'(int'($urandom_range(8191)) - 4096);
		endcase
	endfunction

	function automatic logic signed [SW-1:0] nudge(input logic signed [SW-1:0] x, input int span);
		int s;
		s = int'(x) + int'($urandom_range(2 * span)) - span;
		if (s > int'(S_MAX))
			s = int'(S_MAX);
		if (s < int'(S_MIN))
			s = int'(S_MIN);
		return SW'(s);
	endfunction

	// mostly pairs close in angle or opposite, so the error lands near the band edges
	function automatic vec_pair_t random_pair();
		vec_pair_t v;
		int span;
		v.target_a = random_component();
		v.target_b = random_component();
		case ($urandom_range(3))
			0: begin
				v.meas_a = random_component();
				v.meas_b = random_component();
			end
			1, 2: begin
				case ($urandom_range(2))
					0: span = 1;
					1: span = 16;
					default: span = 4096;
				endcase
				v.meas_a = nudge(v.target_a, span);
				v.meas_b = nudge(v.target_b, span);
			end
			default: begin
				v.meas_a = nudge(~v.target_a, 1);
				v.meas_b = nudge(~v.target_b, 1);
			end
		endcase
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			mismatches++;
		end
	endfunction

	task automatic offer(input vec_pair_t v, input bit typed, input polar_result_t want);
		polar_result_t guess;
		if (!quiet && $urandom_range(99) < 7) begin
			item_ch.valid <= 1'b0;
			// idle until the block has been ready at least once with no beat offered
			do @(posedge clk);
			while (item_ch.ready !== 1'b1 || (!quiet && $urandom_range(99) < 7));
		end
		item_ch.valid <= 1'b1;
		item_ch.meas_a <= v.meas_a;
		item_ch.meas_b <= v.meas_b;
		item_ch.target_a <= v.target_a;
		item_ch.target_b <= v.target_b;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		guess = predict_polar(v);
		awaited_results.push_back(typed ? want : guess);
	endtask

	task automatic write_reg(input logic sel, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (sel == REG_PHASE_BAND)
			band_setting = data[BAND_W-1:0];
		else
			thr_setting = data[NORM_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_reg(input logic sel);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (sel == REG_PHASE_BAND)
			check_field("phase_band", 32'(band_setting), prdata);
		else
			check_field("norm_threshold", 32'(thr_setting), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drained();
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [BAND_W-1:0] band, input logic [NORM_W-1:0] thr,
		input int n, input bit no_idle);
		wait_drained();
		// upper garbage bits must be dropped by the register
		write_reg(REG_PHASE_BAND, ($urandom() << BAND_W) | 32'(band));
		write_reg(REG_NORM_THR, ($urandom() << NORM_W) | 32'(thr));
		read_reg(REG_PHASE_BAND);
		read_reg(REG_NORM_THR);
		quiet = no_idle;
		repeat (n) offer(random_pair(), 1'b0, NO_WANT);
		item_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin : result_sink
		polar_result_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("meas_magnitude", want.meas_magnitude, result_ch.meas_magnitude);
				check_field("target_magnitude", want.target_magnitude,
					result_ch.target_magnitude);
				check_field("meas_phase", want.meas_phase, result_ch.meas_phase);
				check_field("target_phase", want.target_phase, result_ch.target_phase);
				check_field("phase_error", want.phase_error, result_ch.phase_error);
				check_field("zero_vector_flag", want.zero_vector_flag,
					result_ch.zero_vector_flag);
				check_field("integrate_enable", want.integrate_enable,
					result_ch.integrate_enable);
			end
		end
		result_ch.ready <= quiet || ($urandom_range(99) >= 7);
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.meas_a = '0;
		item_ch.meas_b = '0;
		item_ch.target_a = '0;
		item_ch.target_b = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		read_reg(REG_PHASE_BAND);
		read_reg(REG_NORM_THR);
		for (int k = 0; k < $size(DIRECTED); k++)
			offer(DIRECTED[k].v, DIRECTED[k].typed, DIRECTED[k].want);
		repeat (120) offer(random_pair(), 1'b0, NO_WANT);
		item_ch.valid <= 1'b0;

		run_phase('0, '0, 130, 1'b0);
		run_phase({BAND_W{1'b1}}, {NORM_W{1'b1}}, 120, 1'b1);
		run_phase(BAND_W'($urandom()), NORM_W'($urandom_range(40)), 110, 1'b0);
		run_phase(BAND_W'($urandom_range(64)), NORM_W'($urandom()), 110, 1'b0);
		run_phase(BAND_W'($urandom()), NORM_W'($urandom_range(8192)), 110, 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
